// ===== rtl/core/tls_sni_pkg.sv =====
`timescale 1ns / 1ps

package tls_sni_pkg;

  // Sums of a position and a 16-bit length field plus a small margin.
  localparam int SUM_W = 18;

  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  VER_MAJOR       = 8'h03;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;

  // Record header length, and the hello fields ahead of the session id
  // length: type, 24-bit length, version and the 32-byte random.
  localparam logic [SUM_W-1:0] REC_HDR_LEN = SUM_W'(5);
  localparam logic [SUM_W-1:0] HELLO_FIXED = SUM_W'(1 + 3 + 2 + 32);

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

endpackage

// ===== rtl/core/tls_client_hello_sni_locator.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall   data_byte, payload_length, last_byte
// out_     output     out_valid/out_stall status, name_offset, name_length
//
// One payload byte is taken every cycle while in_stall is low. Each byte lands in the
// input register, then header and length checks on it update the parser state.
// The result of a payload is written to the output register when its last byte
// leaves the input register. Reset is synchronous and clears the parser and both valids.
// in_stall rises only while a last byte waits in the input register behind a
// result that has not been taken.

module tls_client_hello_sni_locator #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_payload_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_name_offset,
  output logic [15:0] out_name_length
);

  localparam int P  = LENGTH_BITS;
  localparam int PW = LENGTH_BITS + 1;
  localparam int S  = tls_sni_pkg::SUM_W;

  typedef enum logic [4:0] {
    PH_START, PH_REC_TYPE, PH_REC_MAJ, PH_REC_MIN, PH_REC_LHI, PH_REC_LLO,
    PH_HS_TYPE, PH_SID_LEN, PH_CIP_HI, PH_CIP_LO, PH_CMP_LEN, PH_EXS_HI,
    PH_EXS_LO, PH_EXT_THI, PH_EXT_TLO, PH_EXT_LHI, PH_EXT_LLO, PH_SNL_HI,
    PH_SNL_LO, PH_SN_TYPE, PH_SN_LHI, PH_SN_LLO, PH_DONE
  } phase_t;

  // Input register.
  logic         in_v_r;
  logic [7:0]   in_byte_r;
  logic [P-1:0] in_len_r;
  logic         in_last_r;

  // Parser state.
  phase_t              phase_r, phase_nxt;
  logic [P-1:0]        pos_r, pos_nxt;
  logic [P-1:0]        skip_r, skip_nxt;
  logic [PW-1:0]       rec_end_r, rec_end_nxt;
  logic [PW-1:0]       ext_end_r, ext_end_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic [15:0]         kind_r, kind_nxt;
  logic [15:0]         found_off_r, found_off_nxt;
  logic [15:0]         found_len_r, found_len_nxt;
  tls_sni_pkg::status_t status_r, status_nxt;

  // Output register.
  logic                 out_v_r;
  tls_sni_pkg::status_t out_status_r;
  logic [15:0]          out_off_r;
  logic [15:0]          out_len_r;

  logic proc;
  logic out_free;

  assign out_free = !out_v_r || !out_stall;
  assign proc     = in_v_r && (!in_last_r || out_free);
  assign in_stall = in_v_r && !proc;

  always_comb begin
    logic [S-1:0]  pos_s, end_s, pos1, v, tgt, rec_cur, ext_cur, e_nx;
    logic [S-1:0]  p_s, snd, avail, mlen, rec_new, ext_new, diff;
    logic          do_sr, do_nx, do_sched, do_fin;
    phase_t        ph_eff, sched_ph;
    tls_sni_pkg::status_t fin_st;

    pos_s    = S'(pos_r);
    end_s    = S'(in_len_r);
    pos1     = pos_s + S'(1);
    v        = S'({acc_r, in_byte_r});
    tgt      = '0;
    rec_cur  = S'(rec_end_r);
    ext_cur  = S'(ext_end_r);
    e_nx     = '0;
    p_s      = '0;
    snd      = '0;
    avail    = '0;
    mlen     = '0;
    rec_new  = '0;
    ext_new  = '0;
    diff     = '0;
    do_sr    = 1'b0;
    do_nx    = 1'b0;
    do_sched = 1'b0;
    do_fin   = 1'b0;
    sched_ph = PH_DONE;
    fin_st   = tls_sni_pkg::ST_NONE;

    phase_nxt     = phase_r;
    skip_nxt      = skip_r;
    rec_end_nxt   = rec_end_r;
    ext_end_nxt   = ext_end_r;
    acc_nxt       = acc_r;
    kind_nxt      = kind_r;
    found_off_nxt = found_off_r;
    found_len_nxt = found_len_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r + P'(1);

    // The first record header starts at the current byte.
    ph_eff = phase_r;
    if (phase_r == PH_START) begin
      if (pos_s + tls_sni_pkg::REC_HDR_LEN < end_s) begin
        ph_eff = PH_REC_TYPE;
      end else begin
        ph_eff     = PH_DONE;
        status_nxt = tls_sni_pkg::ST_NONE;
      end
      phase_nxt = ph_eff;
    end

    if (ph_eff != PH_DONE) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - P'(1);
      end else begin
        case (ph_eff)
          PH_REC_TYPE: begin
            kind_nxt  = {8'h00, in_byte_r};
            phase_nxt = PH_REC_MAJ;
          end
          PH_REC_MAJ: begin
            if (in_byte_r != tls_sni_pkg::VER_MAJOR) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_NONE;
            end else begin
              phase_nxt = PH_REC_MIN;
            end
          end
          PH_REC_MIN: phase_nxt = PH_REC_LHI;
          PH_REC_LHI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_REC_LLO;
          end
          PH_REC_LLO: begin
            // The record length is clipped to what remains of the payload.
            avail       = (end_s > pos1) ? (end_s - pos1) : '0;
            mlen        = (v < avail) ? v : avail;
            rec_new     = pos1 + mlen;
            rec_cur     = rec_new;
            rec_end_nxt = rec_new[PW-1:0];
            if (kind_r != {8'h00, tls_sni_pkg::REC_HANDSHAKE}) begin
              do_sr = 1'b1;
            end else if (pos1 + S'(1) >= rec_new) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              do_sched = 1'b1;
              tgt      = pos1;
              sched_ph = PH_HS_TYPE;
            end
          end
          PH_HS_TYPE: begin
            p_s = pos_s + tls_sni_pkg::HELLO_FIXED;
            if (in_byte_r != tls_sni_pkg::HS_CLIENT_HELLO) begin
              do_sr = 1'b1;
            end else if (p_s + S'(1) >= rec_cur) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              do_sched = 1'b1;
              tgt      = p_s;
              sched_ph = PH_SID_LEN;
            end
          end
          PH_SID_LEN, PH_CMP_LEN: begin
            p_s = pos1 + S'(in_byte_r);
            if (p_s + S'(2) >= rec_cur) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              do_sched = 1'b1;
              tgt      = p_s;
              sched_ph = (ph_eff == PH_SID_LEN) ? PH_CIP_HI : PH_EXS_HI;
            end
          end
          PH_CIP_HI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_CIP_LO;
          end
          PH_CIP_LO: begin
            p_s = pos1 + v;
            if (p_s + S'(1) >= rec_cur) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              do_sched = 1'b1;
              tgt      = p_s;
              sched_ph = PH_CMP_LEN;
            end
          end
          PH_EXS_HI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_EXS_LO;
          end
          PH_EXS_LO: begin
            p_s         = pos1 + v;
            ext_new     = (p_s > rec_cur) ? rec_cur : p_s;
            ext_cur     = ext_new;
            ext_end_nxt = ext_new[PW-1:0];
            e_nx        = pos1;
            do_nx       = 1'b1;
          end
          PH_EXT_THI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_EXT_TLO;
          end
          PH_EXT_TLO: begin
            kind_nxt  = v[15:0];
            phase_nxt = PH_EXT_LHI;
          end
          PH_EXT_LHI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_EXT_LLO;
          end
          PH_EXT_LLO: begin
            p_s = pos1 + v;
            if (p_s > ext_cur) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else if (kind_r != tls_sni_pkg::EXT_SERVER_NAME) begin
              e_nx  = p_s;
              do_nx = 1'b1;
            end else if (pos1 + S'(2) >= ext_cur) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              do_sched = 1'b1;
              tgt      = pos1;
              sched_ph = PH_SNL_HI;
            end
          end
          PH_SNL_HI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_SNL_LO;
          end
          PH_SNL_LO: begin
            // From here on the extensions end marks the end of the name list.
            snd = pos1 + v;
            if (snd > ext_cur || pos1 + S'(3) >= snd) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              ext_end_nxt = snd[PW-1:0];
              phase_nxt   = PH_SN_TYPE;
            end
          end
          PH_SN_TYPE: phase_nxt = PH_SN_LHI;
          PH_SN_LHI: begin
            acc_nxt   = in_byte_r;
            phase_nxt = PH_SN_LLO;
          end
          PH_SN_LLO: begin
            if (pos1 + v > ext_cur) begin
              do_fin = 1'b1;
              fin_st = tls_sni_pkg::ST_BAD;
            end else begin
              found_off_nxt = pos1[15:0];
              found_len_nxt = v[15:0];
              do_fin        = 1'b1;
              fin_st        = tls_sni_pkg::ST_FOUND;
            end
          end
          default: begin
            do_fin = 1'b1;
            fin_st = tls_sni_pkg::ST_NONE;
          end
        endcase
      end
    end

    // Step to the next extension, or past the record when the list is done.
    if (do_nx) begin
      if (e_nx >= ext_cur) begin
        do_sr = 1'b1;
      end else if (e_nx + S'(4) >= ext_cur) begin
        do_fin = 1'b1;
        fin_st = tls_sni_pkg::ST_BAD;
      end else begin
        do_sched = 1'b1;
        tgt      = e_nx;
        sched_ph = PH_EXT_THI;
      end
    end

    // Next record starts at the current record end if a full header fits.
    if (do_sr) begin
      if (rec_cur + tls_sni_pkg::REC_HDR_LEN < end_s) begin
        do_sched = 1'b1;
        tgt      = rec_cur;
        sched_ph = PH_REC_TYPE;
      end else begin
        do_fin = 1'b1;
        fin_st = tls_sni_pkg::ST_NONE;
      end
    end

    if (do_sched) begin
      diff      = tgt - pos_s - S'(1);
      skip_nxt  = (tgt > pos_s) ? diff[P-1:0] : '0;
      phase_nxt = sched_ph;
    end

    if (do_fin) begin
      status_nxt = fin_st;
      phase_nxt  = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_len_r  <= in_payload_length[P-1:0];
      in_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proc && in_last_r)) begin
      phase_r     <= PH_START;
      pos_r       <= '0;
      skip_r      <= '0;
      rec_end_r   <= '0;
      ext_end_r   <= '0;
      acc_r       <= '0;
      kind_r      <= '0;
      found_off_r <= '0;
      found_len_r <= '0;
      status_r    <= tls_sni_pkg::ST_NONE;
    end else if (proc) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      skip_r      <= skip_nxt;
      rec_end_r   <= rec_end_nxt;
      ext_end_r   <= ext_end_nxt;
      acc_r       <= acc_nxt;
      kind_r      <= kind_nxt;
      found_off_r <= found_off_nxt;
      found_len_r <= found_len_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last_r) begin
      out_status_r <= status_nxt;
      out_off_r    <= (status_nxt == tls_sni_pkg::ST_FOUND) ? found_off_nxt : '0;
      out_len_r    <= (status_nxt == tls_sni_pkg::ST_FOUND) ? found_len_nxt : '0;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_status_r;
  assign out_name_offset = out_off_r;
  assign out_name_length = out_len_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LENGTH_BITS = 16;

  typedef enum logic [4:0] {
    W_START, W_REC_TYPE, W_REC_MAJ, W_REC_MIN, W_REC_LHI, W_REC_LLO,
    W_HS_TYPE, W_SID_LEN, W_CIP_HI, W_CIP_LO, W_CMP_LEN, W_EXS_HI, W_EXS_LO,
    W_EXT_THI, W_EXT_TLO, W_EXT_LHI, W_EXT_LLO, W_SNL_HI, W_SNL_LO,
    W_SN_TYPE, W_SN_LHI, W_SN_LLO, W_DONE
  } walk_t;

  typedef struct {
    tls_sni_pkg::status_t status;
    logic [15:0]          name_offset;
    logic [15:0]          name_length;
  } name_hit_t;

  // Walks the payload alongside the block and keeps the verdicts still owed.
  class sni_scoreboard;
    walk_t                phase;
    int unsigned          pos, skip_cnt, rec_end, ext_end, acc, kind, name_off, name_len;
    int unsigned          pos_mask;
    tls_sni_pkg::status_t verdict;
    name_hit_t            pending_hits[$];
    int                   errors;

    function new(int bits);
      pos_mask = (1 << bits) - 1;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = W_START;
      pos = 0;
      skip_cnt = 0;
      rec_end = 0;
      ext_end = 0;
      acc = 0;
      kind = 0;
      name_off = 0;
      name_len = 0;
      verdict = tls_sni_pkg::ST_NONE;
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction

    function void finish_walk(tls_sni_pkg::status_t s);
      verdict = s;
      phase = W_DONE;
    endfunction

    // The next field of kind ph begins at absolute position target.
    function void schedule(int unsigned p, int unsigned target, walk_t ph);
      skip_cnt = (target > p) ? ((target - p - 1) & 32'hFFFFF) : 0;
      phase = ph;
    endfunction

    function void start_record(int unsigned p, int unsigned rec, int unsigned lim);
      if (rec + tls_sni_pkg::REC_HDR_LEN < lim) schedule(p, rec, W_REC_TYPE);
      else finish_walk(tls_sni_pkg::ST_NONE);
    endfunction

    function void next_extension(int unsigned p, int unsigned e, int unsigned lim);
      if (e >= ext_end) start_record(p, rec_end, lim);
      else if (e + 4 >= ext_end) finish_walk(tls_sni_pkg::ST_BAD);
      else schedule(p, e, W_EXT_THI);
    endfunction

    function void take_byte(int unsigned p, logic [7:0] b, int unsigned lim);
      int unsigned v, at, body, room, rlen, s_end;
      v = ((acc << 8) | b) & 32'hFFFF;
      case (phase)
        W_REC_TYPE: begin
          kind = b;
          phase = W_REC_MAJ;
        end
        W_REC_MAJ: begin
          if (b != tls_sni_pkg::VER_MAJOR) finish_walk(tls_sni_pkg::ST_NONE);
          else phase = W_REC_MIN;
        end
        W_REC_MIN: phase = W_REC_LHI;
        W_REC_LHI: begin
          acc = b;
          phase = W_REC_LLO;
        end
        W_REC_LLO: begin
          body = p + 1;
          room = (lim > body) ? lim - body : 0;
          rlen = (v < room) ? v : room;
          rec_end = body + rlen;
          if (kind != tls_sni_pkg::REC_HANDSHAKE) start_record(p, rec_end, lim);
          else if (body + 1 >= rec_end) finish_walk(tls_sni_pkg::ST_BAD);
          else schedule(p, body, W_HS_TYPE);
        end
        W_HS_TYPE: begin
          if (b != tls_sni_pkg::HS_CLIENT_HELLO) begin
            start_record(p, rec_end, lim);
          end else begin
            at = p + tls_sni_pkg::HELLO_FIXED;
            if (at + 1 >= rec_end) finish_walk(tls_sni_pkg::ST_BAD);
            else schedule(p, at, W_SID_LEN);
          end
        end
        W_SID_LEN: begin
          at = p + 1 + b;
          if (at + 2 >= rec_end) finish_walk(tls_sni_pkg::ST_BAD);
          else schedule(p, at, W_CIP_HI);
        end
        W_CIP_HI: begin
          acc = b;
          phase = W_CIP_LO;
        end
        W_CIP_LO: begin
          at = p + 1 + v;
          if (at + 1 >= rec_end) finish_walk(tls_sni_pkg::ST_BAD);
          else schedule(p, at, W_CMP_LEN);
        end
        W_CMP_LEN: begin
          at = p + 1 + b;
          if (at + 2 >= rec_end) finish_walk(tls_sni_pkg::ST_BAD);
          else schedule(p, at, W_EXS_HI);
        end
        W_EXS_HI: begin
          acc = b;
          phase = W_EXS_LO;
        end
        W_EXS_LO: begin
          ext_end = p + 1 + v;
          if (ext_end > rec_end) ext_end = rec_end;
          next_extension(p, p + 1, lim);
        end
        W_EXT_THI: begin
          acc = b;
          phase = W_EXT_TLO;
        end
        W_EXT_TLO: begin
          kind = v;
          phase = W_EXT_LHI;
        end
        W_EXT_LHI: begin
          acc = b;
          phase = W_EXT_LLO;
        end
        W_EXT_LLO: begin
          at = p + 1;
          if (at + v > ext_end) finish_walk(tls_sni_pkg::ST_BAD);
          else if (kind != tls_sni_pkg::EXT_SERVER_NAME) next_extension(p, at + v, lim);
          else if (at + 2 >= ext_end) finish_walk(tls_sni_pkg::ST_BAD);
          else schedule(p, at, W_SNL_HI);
        end
        W_SNL_HI: begin
          acc = b;
          phase = W_SNL_LO;
        end
        W_SNL_LO: begin
          s_end = p + 1 + v;
          if (s_end > ext_end || p + 4 >= s_end) begin
            finish_walk(tls_sni_pkg::ST_BAD);
          end else begin
            // From here on the name list bounds every further check.
            ext_end = s_end;
            phase = W_SN_TYPE;
          end
        end
        W_SN_TYPE: phase = W_SN_LHI;
        W_SN_LHI: begin
          acc = b;
          phase = W_SN_LLO;
        end
        W_SN_LLO: begin
          at = p + 1;
          if (at + v > ext_end) begin
            finish_walk(tls_sni_pkg::ST_BAD);
          end else begin
            name_off = at & 32'hFFFF;
            name_len = v;
            finish_walk(tls_sni_pkg::ST_FOUND);
          end
        end
        default: finish_walk(tls_sni_pkg::ST_NONE);
      endcase
    endfunction

    function void note_word(logic [7:0] b, logic [15:0] plen, logic last);
      int unsigned lim, p;
      name_hit_t   hit;
      lim = plen & pos_mask;
      p = pos;
      if (phase == W_START) start_record(p, p, lim);
      if (phase != W_DONE) begin
        if (skip_cnt > 0) skip_cnt--;
        else take_byte(p, b, lim);
      end
      pos = (p + 1) & pos_mask;
      if (last) begin
        hit.status = verdict;
        hit.name_offset = (verdict == tls_sni_pkg::ST_FOUND) ? 16'(name_off) : 16'd0;
        hit.name_length = (verdict == tls_sni_pkg::ST_FOUND) ? 16'(name_len) : 16'd0;
        pending_hits.push_back(hit);
        clear();
      end
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] off, logic [15:0] len);
      name_hit_t want;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no payload pending: status %0d offset %0d length %0d",
                   $realtime, st, off, len);
        return;
      end
      want = pending_hits.pop_front();
      if (st !== want.status || off !== want.name_offset || len !== want.name_length) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected status %0d offset %0d length %0d, got %0d %0d %0d",
                   $realtime, want.status, want.name_offset, want.name_length, st, off, len);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic [15:0] in_payload_length = 16'd1;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_name_offset;
  logic [15:0] out_name_length;

  sni_scoreboard sb;
  logic [7:0]    pkt[$];
  logic [15:0]   pkt_len;
  int            words_sent = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  tls_client_hello_sni_locator #(.LENGTH_BITS(LENGTH_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_payload_length (in_payload_length),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_name_offset   (out_name_offset),
    .out_name_length   (out_name_length)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_name_offset, out_name_length);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #36_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void push16(int unsigned v);
    pkt.push_back(8'(v >> 8));
    pkt.push_back(8'(v));
  endfunction

  function automatic void patch16(int at, int unsigned v);
    pkt[at] = 8'(v >> 8);
    pkt[at + 1] = 8'(v);
  endfunction

  function automatic void push_rand(int n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic void push_ext();
    int n;
    n = $urandom_range(4);
    push16($urandom_range(16'hFFFF, 1));
    push16(n);
    push_rand(n);
  endfunction

  // Appends a ClientHello record, sometimes behind a record the walk must skip.
  function automatic void build_hello();
    int rec_at, hs_at, ext_at, n;
    logic [7:0] t;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(8, 2);
      if ($urandom_range(1) == 0) begin
        pkt.push_back(tls_sni_pkg::REC_HANDSHAKE);
        pkt.push_back(tls_sni_pkg::VER_MAJOR);
        pkt.push_back(8'($urandom));
        push16(n);
        pkt.push_back(8'($urandom_range(255, 2)));
        push_rand(n - 1);
      end else begin
        t = 8'($urandom_range(8'h17, 8'h14));
        if (t == tls_sni_pkg::REC_HANDSHAKE) t = 8'h17;
        pkt.push_back(t);
        pkt.push_back(tls_sni_pkg::VER_MAJOR);
        pkt.push_back(8'($urandom));
        push16(n);
        push_rand(n);
      end
    end
    rec_at = pkt.size();
    pkt.push_back(tls_sni_pkg::REC_HANDSHAKE);
    pkt.push_back(tls_sni_pkg::VER_MAJOR);
    pkt.push_back(8'($urandom_range(4)));
    push16(0);
    hs_at = pkt.size();
    pkt.push_back(($urandom_range(15) == 0) ? 8'($urandom_range(255, 2))
                                            : tls_sni_pkg::HS_CLIENT_HELLO);
    push_rand(3);
    pkt.push_back(tls_sni_pkg::VER_MAJOR);
    pkt.push_back(8'h03);
    push_rand(32);
    n = ($urandom_range(1) == 0) ? 0 : $urandom_range(32);
    pkt.push_back(8'(n));
    push_rand(n);
    n = 2 * $urandom_range(4, 1);
    push16(n);
    push_rand(n);
    n = $urandom_range(2, 1);
    pkt.push_back(8'(n));
    push_rand(n);
    ext_at = pkt.size();
    push16(0);
    repeat ($urandom_range(2)) push_ext();
    if ($urandom_range(6) != 0) begin
      n = $urandom_range(24, 1);
      push16(tls_sni_pkg::EXT_SERVER_NAME);
      push16(n + 5);
      push16(n + 3);
      // The name type byte is passed over without a check.
      pkt.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
      push16(n);
      push_rand(n);
    end
    repeat ($urandom_range(1)) push_ext();
    patch16(ext_at, pkt.size() - ext_at - 2);
    patch16(rec_at + 3, pkt.size() - hs_at);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic [15:0] plen, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_payload_length <= plen;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(b, plen, last);
    words_sent++;
  endtask

  // With wobble set, the stated payload length changes now and then mid-payload.
  task automatic send_packet(input bit wobble);
    logic [15:0] plen;
    for (int i = 0; i < pkt.size(); i++) begin
      plen = pkt_len;
      if (wobble && $urandom_range(9) == 0) plen = 16'($urandom);
      send_word(pkt[i], plen, i == pkt.size() - 1);
    end
  endtask

  task automatic random_packet();
    int pick, n, k;
    bit wobble;
    pkt.delete();
    pick = $urandom_range(99);
    if (pick < 12) begin
      if ($urandom_range(1) == 0) begin
        pkt.push_back(tls_sni_pkg::REC_HANDSHAKE);
        pkt.push_back(tls_sni_pkg::VER_MAJOR);
      end
      push_rand($urandom_range(40, 1));
    end else begin
      build_hello();
      if (pick < 35) begin
        if ($urandom_range(2) == 0) begin
          n = $urandom_range(pkt.size(), 1);
          while (pkt.size() > n) void'(pkt.pop_back());
        end else begin
          repeat ($urandom_range(3, 1)) pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
        end
      end else if (pick < 45) begin
        // Trailing bytes after the verdict is settled.
        push_rand($urandom_range(6, 1));
      end
    end
    pkt_len = 16'(pkt.size());
    k = $urandom_range(19);
    if (k == 0) pkt_len = 16'($urandom_range(16'hFFFF, 1));
    else if (k < 3) pkt_len = 16'($urandom_range(pkt.size() + 60, pkt.size() + 1));
    else if (k < 5) pkt_len = 16'($urandom_range(pkt.size(), 1));
    wobble = ($urandom_range(19) == 0);
    send_packet(wobble);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int start_words, packets;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start_words = words_sent;
    packets = 0;
    while (words_sent - start_words < 500 || packets < 4) begin
      random_packet();
      packets++;
    end
  endtask

  initial begin
    sb = new(LENGTH_BITS);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Payload that ends on its first byte.
    pkt = '{8'h16};
    pkt_len = 16'd1;
    send_packet(1'b0);
    // Wrong major version; the rest of the payload is ignored.
    pkt = '{8'h16, 8'h02, 8'h03, 8'h00};
    pkt_len = 16'd6;
    send_packet(1'b0);
    // ClientHello cut short by a record clipped to the payload.
    pkt = '{8'h16, 8'h03, 8'h01, 8'h00, 8'h05, 8'h01, 8'hFF};
    pkt_len = 16'd7;
    send_packet(1'b0);
    // Long non-handshake record that the payload ends inside.
    pkt = '{8'h17, 8'h03, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    pkt_len = 16'hFFFF;
    send_packet(1'b0);
    // Handshake record too short to hold a handshake type and more.
    pkt = '{8'h16, 8'h03, 8'h03, 8'h00, 8'h01, 8'h00};
    pkt_len = 16'd6;
    send_packet(1'b0);

    run_phase(0, 0);
    run_phase(63, 0);
    run_phase(0, 63);
    run_phase(21, 21);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
